// ===== src/mns_pkg.sv =====
// Shared types, codes and the note scale table for the melody note sequencer.
`default_nettype none
package mns_pkg;

  // Item modes
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_LOAD  = 2'd1;
  localparam logic [1:0] MODE_START = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_SONG_TIME      = 2'd0;
  localparam logic [1:0] CFG_SONG_ENTRIES   = 2'd1;
  localparam logic [1:0] CFG_PAUSE_CODE     = 2'd2;
  localparam logic [1:0] CFG_SHORT_DURATION = 2'd3;

  localparam int unsigned NUM_W   = 32;  // duration * scale
  localparam int unsigned DEN_W   = 26;  // 1000 * song_time
  localparam int unsigned CNT_W   = 5;   // divider step counter
  localparam int unsigned COUNT_W = 24;  // tick counters

  localparam logic [7:0]  NOTE_COUNT  = 8'd36;
  // Pause: d*7500/t == d*7500000/(1000*t)
  localparam logic [23:0] PAUSE_SCALE = 24'd7500000;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  // 75 * note frequency in centihertz, C4 up to B6
  function automatic logic [23:0] note_scale(input logic [7:0] code);
    logic [23:0] s;
    case (code)
      8'd0:  s = 24'd1962225;
      8'd1:  s = 24'd2078850;
      8'd2:  s = 24'd2202450;
      8'd3:  s = 24'd2333475;
      8'd4:  s = 24'd2472225;
      8'd5:  s = 24'd2619225;
      8'd6:  s = 24'd2774925;
      8'd7:  s = 24'd2940000;
      8'd8:  s = 24'd3114750;
      8'd9:  s = 24'd3300000;
      8'd10: s = 24'd3496200;
      8'd11: s = 24'd3704100;
      8'd12: s = 24'd3924375;
      8'd13: s = 24'd4157775;
      8'd14: s = 24'd4404975;
      8'd15: s = 24'd4666875;
      8'd16: s = 24'd4944375;
      8'd17: s = 24'd5238450;
      8'd18: s = 24'd5549925;
      8'd19: s = 24'd5879925;
      8'd20: s = 24'd6229575;
      8'd21: s = 24'd6600000;
      8'd22: s = 24'd6992475;
      8'd23: s = 24'd7408275;
      8'd24: s = 24'd7848750;
      8'd25: s = 24'd8315475;
      8'd26: s = 24'd8809950;
      8'd27: s = 24'd9333825;
      8'd28: s = 24'd9888825;
      8'd29: s = 24'd10476825;
      8'd30: s = 24'd11099850;
      8'd31: s = 24'd11759850;
      8'd32: s = 24'd12459150;
      8'd33: s = 24'd13200000;
      8'd34: s = 24'd13984950;
      8'd35: s = 24'd14816475;
      default: s = PAUSE_SCALE;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== src/melody_note_sequencer.sv =====
// Melody note sequencer top level: control sequencer, configuration and result register.
// Plays a song of (note, duration) entries held in an on-chip song memory. A load
// transaction writes one entry, a start transaction restarts play from entry 0, and
// each tick transaction counts the current note down; when it reaches zero the next
// entry is read and its tick count and 32nd-note gap are computed as
// floor(d*75*f/(1000*song_time)) (real note, f in centihertz) or
// floor(d*7500/song_time) (pause). Every input transaction yields exactly one result
// transaction. A load, mode 3 and a tick that does not fetch go from idle to S_RESULT,
// which writes the result register; no new input is taken until then. A transaction
// that reads an entry passes S_FETCH and S_READ, then runs the restoring divider twice
// (tick count, then gap), each run being a start, 32 one-bit steps and a collect. A
// fetch that finds the song ended goes from S_FETCH to S_RESULT. A stalled output holds
// the new result back in S_RESULT. The input is taken only while the sequencer is idle,
// which may be while a previous result is still waiting on the output register. There
// is no clearing pass after reset; entries must be loaded before they are played. The
// user must write configuration only while the block is idle; the block itself does
// not enforce this.
`default_nettype none
module melody_note_sequencer import mns_pkg::*; #(
  parameter int unsigned SONG_DEPTH = 256
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_mode,
  input  wire logic [7:0] in_entry_index,
  input  wire logic [7:0] in_note_code,
  input  wire logic [7:0] in_duration_code,
  // result channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_sound_on,
  output logic            out_playing,
  output logic            out_note_sounding,
  output logic            out_finished,
  output logic [8:0]      out_current_entry,
  // configuration
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int unsigned AW      = (SONG_DEPTH > 1) ? $clog2(SONG_DEPTH) : 1;
  localparam logic [12:0] DEPTH_V = 13'(SONG_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_READ,
    S_TICKMUL,
    S_TICKDIV,
    S_GAPMUL,
    S_GAPDIV,
    S_RESULT
  } state_t;

  // configuration registers
  logic [15:0] song_time_r;
  logic [8:0]  song_entries_r;
  logic [7:0]  pause_code_r;
  logic [7:0]  short_dur_r;

  // control state
  state_t         state_r, state_nxt;
  logic [COUNT_W-1:0] tick_count_r, tick_count_nxt;
  logic [COUNT_W-1:0] gap_ticks_r, gap_ticks_nxt;
  logic [8:0]     next_entry_r, next_entry_nxt;
  logic           play_r, play_nxt;
  logic           note_flag_r, note_flag_nxt;
  logic           finished_r, finished_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_sound_r, out_sound_nxt;
  logic           out_play_r, out_play_nxt;
  logic           out_note_r, out_note_nxt;
  logic           out_fin_r, out_fin_nxt;
  logic [8:0]     out_entry_r, out_entry_nxt;

  // per-fetch operands (no reset)
  logic [23:0]    scale_r;
  logic [7:0]     dur_r;
  logic [DEN_W-1:0] den_r;
  logic           is_note_r;

  logic           accept;
  logic           entry_ok;
  logic           idx_ok;
  logic           mem_we;
  logic           mem_re;
  logic [15:0]    mem_rdata;
  logic [7:0]     rd_note;
  logic [7:0]     rd_dur;
  logic           rd_is_note;
  logic [15:0]    eff_time;
  logic [7:0]     mul_dur;
  div_req_t       div_req;
  logic           div_done;
  logic [NUM_W-1:0] div_quot;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // entry available: inside the song and inside the memory
  assign entry_ok = ({4'b0, next_entry_r} < DEPTH_V) && (next_entry_r < song_entries_r);
  assign idx_ok   = ({5'b0, in_entry_index} < DEPTH_V);

  assign mem_we = accept && (in_mode == MODE_LOAD) && idx_ok;
  assign mem_re = (state_r == S_FETCH) && entry_ok;

  mns_song_mem #(
    .DEPTH (SONG_DEPTH),
    .AW    (AW)
  ) u_song_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (AW'(in_entry_index)),
    .wr_data ({in_duration_code, in_note_code}),
    .rd_en   (mem_re),
    .rd_addr (AW'(next_entry_r)),
    .rd_data (mem_rdata)
  );

  // entry: duration in the high byte, note in the low byte
  assign rd_note    = mem_rdata[7:0];
  assign rd_dur     = mem_rdata[15:8];
  // out-of-table codes play as pauses
  assign rd_is_note = (rd_note != pause_code_r) && (rd_note < NOTE_COUNT);
  assign eff_time   = (song_time_r == 16'd0) ? 16'd1 : song_time_r;

  // one divider serves both the note length and the gap
  assign mul_dur       = (state_r == S_GAPMUL) ? short_dur_r : dur_r;
  assign div_req.start = (state_r == S_TICKMUL) || (state_r == S_GAPMUL);
  assign div_req.num   = NUM_W'(mul_dur) * NUM_W'(scale_r);
  assign div_req.den   = den_r;

  mns_divider u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_quot)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      song_time_r    <= 16'd120;
      song_entries_r <= 9'd0;
      pause_code_r   <= 8'd255;
      short_dur_r    <= 8'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SONG_TIME:      song_time_r    <= cfg_data;
        CFG_SONG_ENTRIES:   song_entries_r <= cfg_data[8:0];
        CFG_PAUSE_CODE:     pause_code_r   <= cfg_data[7:0];
        CFG_SHORT_DURATION: short_dur_r    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // fetch operands captured from the memory read
  always_ff @(posedge clk) begin
    if (state_r == S_READ) begin
      scale_r   <= rd_is_note ? note_scale(rd_note) : PAUSE_SCALE;
      dur_r     <= rd_dur;
      den_r     <= DEN_W'(eff_time) * DEN_W'(1000);
      is_note_r <= rd_is_note;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    tick_count_nxt = tick_count_r;
    gap_ticks_nxt  = gap_ticks_r;
    next_entry_nxt = next_entry_r;
    play_nxt       = play_r;
    note_flag_nxt  = note_flag_r;
    finished_nxt   = finished_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_sound_nxt  = out_sound_r;
    out_play_nxt   = out_play_r;
    out_note_nxt   = out_note_r;
    out_fin_nxt    = out_fin_r;
    out_entry_nxt  = out_entry_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          finished_nxt = 1'b0;
          state_nxt    = S_RESULT;
          unique case (in_mode)
            MODE_TICK: begin
              // an idle count ignores ticks
              if (tick_count_r != '0) begin
                tick_count_nxt = tick_count_r - 1'b1;
                if (tick_count_r == COUNT_W'(1)) begin
                  state_nxt = S_FETCH;
                end
              end
            end
            MODE_START: begin
              play_nxt       = 1'b1;
              next_entry_nxt = 9'd0;
              state_nxt      = S_FETCH;
            end
            default: ;  // load handled by the memory port, mode 3 does nothing
          endcase
        end
      end
      S_FETCH: begin
        if (entry_ok) begin
          state_nxt = S_READ;
        end else begin
          play_nxt     = 1'b0;
          finished_nxt = 1'b1;
          state_nxt    = S_RESULT;
        end
      end
      S_READ:    state_nxt = S_TICKMUL;
      S_TICKMUL: state_nxt = S_TICKDIV;
      S_TICKDIV: begin
        if (div_done) begin
          tick_count_nxt = div_quot[COUNT_W-1:0];
          state_nxt      = S_GAPMUL;
        end
      end
      S_GAPMUL:  state_nxt = S_GAPDIV;
      S_GAPDIV: begin
        if (div_done) begin
          gap_ticks_nxt  = div_quot[COUNT_W-1:0];
          note_flag_nxt  = is_note_r;
          next_entry_nxt = next_entry_r + 1'b1;
          state_nxt      = S_RESULT;
        end
      end
      S_RESULT: begin
        // wait for the output register to free up
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_sound_nxt = note_flag_r && (tick_count_r > gap_ticks_r);
          out_play_nxt  = play_r;
          out_note_nxt  = note_flag_r;
          out_fin_nxt   = finished_r;
          out_entry_nxt = next_entry_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      tick_count_r <= '0;
      gap_ticks_r  <= '0;
      next_entry_r <= 9'd0;
      play_r       <= 1'b0;
      note_flag_r  <= 1'b0;
      finished_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      out_sound_r  <= 1'b0;
      out_play_r   <= 1'b0;
      out_note_r   <= 1'b0;
      out_fin_r    <= 1'b0;
      out_entry_r  <= 9'd0;
    end else begin
      state_r      <= state_nxt;
      tick_count_r <= tick_count_nxt;
      gap_ticks_r  <= gap_ticks_nxt;
      next_entry_r <= next_entry_nxt;
      play_r       <= play_nxt;
      note_flag_r  <= note_flag_nxt;
      finished_r   <= finished_nxt;
      out_valid_r  <= out_valid_nxt;
      out_sound_r  <= out_sound_nxt;
      out_play_r   <= out_play_nxt;
      out_note_r   <= out_note_nxt;
      out_fin_r    <= out_fin_nxt;
      out_entry_r  <= out_entry_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sound_on      = out_sound_r;
  assign out_playing       = out_play_r;
  assign out_note_sounding = out_note_r;
  assign out_finished      = out_fin_r;
  assign out_current_entry = out_entry_r;

  // one transaction in flight at a time
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("input accepted while a transaction was in progress");

  // divider results only land where the sequencer waits for them
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_TICKDIV || state_r == S_GAPDIV))
    else $error("divider finished outside a wait state");

  // memory is read only inside the song
  a_read_in_song: assert property (@(posedge clk) disable iff (!rst_n)
    mem_re |-> (next_entry_r < song_entries_r))
    else $error("song memory read past the song end");

  // a tick on a zero count changes nothing and goes straight to the result
  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_mode == MODE_TICK && tick_count_r == '0
      |=> tick_count_r == '0 && state_r == S_RESULT)
    else $error("tick on zero count disturbed the counter");

  // an end of play result never reports play in progress
  a_finish_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_finished |-> !out_playing)
    else $error("finished result shows play still running");

endmodule
`default_nettype wire

// ===== src/mns_song_mem.sv =====
// Song entry memory: one write port, one registered read port.
`default_nettype none
module mns_song_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [15:0]   wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [15:0]   rd_data
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== src/mns_divider.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module mns_divider import mns_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire div_req_t         req,
  output logic                  done,
  output logic [NUM_W-1:0]      quot
);

  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_dif;
  logic             ge;
  logic [DEN_W-1:0] rem_nxt;

  assign rem_sh  = {rem_r, num_r[NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_dif = rem_sh - {1'b0, den_r};
  // remainder stays below den, so the top bit drops out
  assign rem_nxt = ge ? rem_dif[DEN_W-1:0] : rem_sh[DEN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= req.num;
      den_r <= req.den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[NUM_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quot = num_r;

endmodule
`default_nettype wire
